// ----- design/prime_factor_counter_unit_assert.svh -----
// Assertion macros for the prime factor counter unit.
// Used by the top level only; needs nothing else.
`ifndef PRIME_FACTOR_COUNTER_UNIT_ASSERT_SVH
`define PRIME_FACTOR_COUNTER_UNIT_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define PFC_ASSERT_SAME(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("pfc: same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define PFC_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("pfc: next-cycle check failed");

`endif

// ----- design/pfc_pkg.sv -----
// Shared constants and types of the prime factor counter unit.
// No dependencies.
`default_nettype none

package pfc_pkg;

    // default width of the input value
    localparam int VALUE_WIDTH_DEF = 30;

    // width and ceiling of the factor count
    localparam int COUNT_W = 5;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // status from the divider to the sequencer
    typedef struct packed {
        logic done;
        logic rem_zero;
    } t_div_stat;

endpackage

`default_nettype wire

// ----- design/pfc_in_if.sv -----
// Input channel of the prime factor counter unit: valid, ready and value.
// No dependencies.
`default_nettype none

interface pfc_in_if #(
    parameter int VALUE_WIDTH = 30
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// ----- design/pfc_out_if.sv -----
// Output channel of the prime factor counter unit: valid, ready and result.
// Depends on pfc_pkg for the count width.
`default_nettype none

interface pfc_out_if;
    logic                        valid;
    logic                        ready;
    logic [pfc_pkg::COUNT_W-1:0] factor_count;
    logic                        is_prime;

    modport source (output valid, output factor_count, output is_prime, input ready);
    modport sink   (input valid, input factor_count, input is_prime, output ready);
endinterface

`default_nettype wire

// ----- design/pfc_divider.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on pfc_pkg for the status struct.
`default_nettype none

module pfc_divider #(
    parameter int VALUE_WIDTH = pfc_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [VALUE_WIDTH-1:0] i_dividend,
    input  wire logic [VALUE_WIDTH-1:0] i_divisor,
    output      logic [VALUE_WIDTH-1:0] o_quotient,
    output      pfc_pkg::t_div_stat     o_stat
);
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    logic [CNT_W-1:0]       r_cnt;
    logic                   r_done;
    logic [VALUE_WIDTH-1:0] r_quo;
    logic [VALUE_WIDTH-1:0] r_rem;
    logic [VALUE_WIDTH-1:0] r_div;

    logic [VALUE_WIDTH:0]   rem_sh;
    logic [VALUE_WIDTH:0]   rem_sub;
    logic                   fits;

    // shift in the next dividend bit and trial-subtract the divisor
    always_comb begin
        rem_sh  = {r_rem, r_quo[VALUE_WIDTH-1]};
        rem_sub = rem_sh - {1'b0, r_div};
        fits    = (rem_sh >= {1'b0, r_div});
    end

    // control: iteration counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(VALUE_WIDTH);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: load operands, then one bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[VALUE_WIDTH-2:0], fits};
            r_rem <= fits ? rem_sub[VALUE_WIDTH-1:0] : rem_sh[VALUE_WIDTH-1:0];
        end
    end

    assign o_quotient      = r_quo;
    assign o_stat.done     = r_done;
    assign o_stat.rem_zero = (r_rem == '0);

endmodule

`default_nettype wire

// ----- design/prime_factor_counter_unit.sv -----
// Prime factor counter: takes one value word and returns the number of its
// prime factors counted with multiplicity, plus a prime flag (count of one).
// Factors of two are stripped at one per cycle; then every odd trial divisor
// d with d*d not above the shrinking remainder is tested by one shared
// radix-2 divider. The input is not ready while a value is worked on; a
// finished result waits in the output register while the next value is
// accepted. Counts above 31 saturate at 31.
`default_nettype none

`include "prime_factor_counter_unit_assert.svh"

module prime_factor_counter_unit #(
    parameter int VALUE_WIDTH = pfc_pkg::VALUE_WIDTH_DEF
) (
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    pfc_in_if.sink     i_in,
    pfc_out_if.source  o_out
);
    localparam int SQ_W = VALUE_WIDTH + 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TWO,
        S_CHECK,
        S_DIV,
        S_FINISH
    } t_state;

    t_state                      r_state, n_state;
    logic [VALUE_WIDTH-1:0]      r_n, n_n;
    logic [VALUE_WIDTH-1:0]      r_d, n_d;
    logic [SQ_W-1:0]             r_dsq, n_dsq;
    logic [pfc_pkg::COUNT_W-1:0] r_count, n_count;
    logic                        r_div_start, n_div_start;
    logic                        r_out_valid, n_out_valid;
    logic [pfc_pkg::COUNT_W-1:0] r_out_count, n_out_count;
    logic                        r_out_prime, n_out_prime;

    logic [pfc_pkg::COUNT_W-1:0] count_inc;
    logic [VALUE_WIDTH-1:0]      quotient;
    pfc_pkg::t_div_stat          div_stat;

    // shared divider for the odd trial divisors
    pfc_divider #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_n),
        .i_divisor  (r_d),
        .o_quotient (quotient),
        .o_stat     (div_stat)
    );

    // saturating count step
    assign count_inc = (r_count == pfc_pkg::COUNT_MAX) ? r_count : r_count + 1'b1;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_d         = r_d;
        n_dsq       = r_dsq;
        n_count     = r_count;
        n_div_start = 1'b0;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_count = r_out_count;
        n_out_prime = r_out_prime;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_n     = i_in.value;
                    n_count = '0;
                    n_state = S_TWO;
                end
            end
            S_TWO: begin
                if (r_n < VALUE_WIDTH'(2)) begin
                    n_state = S_FINISH;
                end else if (!r_n[0]) begin
                    n_n     = {1'b0, r_n[VALUE_WIDTH-1:1]};
                    n_count = count_inc;
                end else begin
                    n_d     = VALUE_WIDTH'(3);
                    n_dsq   = SQ_W'(9);
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_dsq <= {2'b00, r_n}) begin
                    n_div_start = 1'b1;
                    n_state     = S_DIV;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    if (div_stat.rem_zero) begin
                        // divide out and try the same divisor again
                        n_n         = quotient;
                        n_count     = count_inc;
                        n_div_start = 1'b1;
                    end else begin
                        // advance to the next odd divisor: (d+2)^2 = d^2 + 4d + 4
                        n_d     = r_d + VALUE_WIDTH'(2);
                        n_dsq   = r_dsq + {r_d, 2'b00} + SQ_W'(4);
                        n_state = S_CHECK;
                    end
                end
            end
            S_FINISH: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    if (r_n > VALUE_WIDTH'(1)) begin
                        n_out_count = count_inc;
                        n_out_prime = (r_count == '0);
                    end else begin
                        n_out_count = r_count;
                        n_out_prime = (r_count == pfc_pkg::COUNT_W'(1));
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_start <= n_div_start;
            r_out_valid <= n_out_valid;
        end
        r_n         <= n_n;
        r_d         <= n_d;
        r_dsq       <= n_dsq;
        r_count     <= n_count;
        r_out_count <= n_out_count;
        r_out_prime <= n_out_prime;
    end

    // take no word while reset is held
    assign i_in.ready         = (r_state == S_IDLE) && i_rst_n;
    assign o_out.valid        = r_out_valid;
    assign o_out.factor_count = r_out_count;
    assign o_out.is_prime     = r_out_prime;

    // an accepted word drops ready until its result is produced
    `PFC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready)
    // prime flag only with a count of one
    `PFC_ASSERT_SAME(a_prime_count, i_clk, i_rst_n, o_out.valid && o_out.is_prime, o_out.factor_count == pfc_pkg::COUNT_W'(1))
    // divider reports only while the sequencer waits on it
    `PFC_ASSERT_SAME(a_div_done_in_div, i_clk, i_rst_n, div_stat.done, r_state == S_DIV)
    // trial divisors are always odd
    `PFC_ASSERT_SAME(a_odd_divisor, i_clk, i_rst_n, r_state == S_CHECK || r_state == S_DIV, r_d[0])

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench for prime_factor_counter_unit: drives value words,
// predicts the factor count and prime flag by trial division, and checks each result.
// Depends on pfc_pkg, pfc_in_if, pfc_out_if and prime_factor_counter_unit from the design folder.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VW = pfc_pkg::VALUE_WIDTH_DEF;
    localparam int CLK_PERIOD = 10;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_WORDS = 84;
    localparam int IDLE_PCT = 18;
    // the largest 30-bit prime needs about 16384 trial divisions
    localparam int STALL_LIMIT = 2_000_000;
    localparam int HOLD_OFF_CYCLES = 6000;
    localparam int HOLD_OFF_AT = 75;
    localparam int DRAIN_CYCLES = 100;
    // words and results in this window are moved without any idling
    localparam int CALM_FIRST = 30;
    localparam int CALM_LAST = 60;

    typedef struct {
        logic [VW-1:0]               value;
        logic [pfc_pkg::COUNT_W-1:0] factor_count;
        logic                        is_prime;
    } t_factor_tally;

    logic clk;
    logic rst_n;

    pfc_in_if #(.VALUE_WIDTH(VW)) in_ch ();
    pfc_out_if                    out_ch ();

    prime_factor_counter_unit #(
        .VALUE_WIDTH(VW)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    logic [VW-1:0] pending_values[$];
    t_factor_tally expected_tallies[$];
    int            words_sent;
    int            results_seen;
    int            mismatches;
    int            hold_off_left;
    bit            hold_off_done;
    int            quiet_cycles;

    // Count prime factors with multiplicity by trial division: twos first,
    // then odd divisors while their square fits in what is left.
    function automatic t_factor_tally tally_prime_factors(input logic [VW-1:0] value);
        t_factor_tally   tally;
        longint unsigned rest;
        longint unsigned divisor;
        int unsigned     count;
        rest  = 64'(value);
        count = 0;
        if (rest >= 2) begin
            while ((rest & 1) == 0) begin
                rest  = rest >> 1;
                count++;
            end
            for (divisor = 3; divisor * divisor <= rest; divisor += 2) begin
                while (rest % divisor == 0) begin
                    rest = rest / divisor;
                    count++;
                end
            end
            if (rest > 1)
                count++;
        end
        if (count > 32'(pfc_pkg::COUNT_MAX))
            count = 32'(pfc_pkg::COUNT_MAX);
        tally.value        = value;
        tally.factor_count = count[pfc_pkg::COUNT_W-1:0];
        tally.is_prime     = (count == 1);
        return tally;
    endfunction

    // Build a value from random small factors, so that high bits and large
    // counts come up at low cost.
    function automatic logic [VW-1:0] smooth_value();
        longint unsigned product;
        longint unsigned factor;
        product = 1;
        repeat ($urandom_range(30, 1)) begin
            factor = 64'($urandom_range(63, 2));
            if (product * factor < (64'd1 << VW))
                product = product * factor;
        end
        return product[VW-1:0];
    endfunction

    // Append one word to the end of the pending queue.
    task automatic queue_word(input logic [VW-1:0] value);
        pending_values.insert(pending_values.size(), value);
    endtask

    // Run the clock and hold reset low for the first cycles.
    initial begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.value  = '0;
        out_ch.ready = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Fill the word queue, wait for it to drain, then report.
    initial begin
        int unsigned pick;
        // zero and one, small primes, prime squares, many-factor values, extremes of the field
        queue_word(VW'(0));
        queue_word(VW'(1));
        queue_word(VW'(2));
        queue_word(VW'(3));
        queue_word(VW'(4));
        queue_word(VW'(9));
        queue_word(VW'(25));
        queue_word(VW'(49));
        queue_word(VW'(97));
        queue_word(VW'(510510));
        queue_word(VW'(387420489));
        queue_word(VW'(1) << (VW - 1));
        queue_word(VW'(3) << (VW - 2));
        queue_word('1);
        queue_word({{(VW - 1){1'b1}}, 1'b0});
        queue_word(VW'(1073741789));

        // mostly small values, a few mid-sized ones, the rest smooth
        repeat (RANDOM_WORDS) begin
            pick = $urandom_range(99, 0);
            if (pick < 55)
                queue_word(VW'($urandom_range(4095, 2)));
            else if (pick < 65)
                queue_word(VW'($urandom_range(1 << 20, 4096)));
            else
                queue_word(smooth_value());
        end

        while (pending_values.size() != 0 || in_ch.valid !== 1'b0 || rst_n !== 1'b1)
            @(posedge clk);
        while (expected_tallies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Offer the next word once the current one is taken, idling at random.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.value <= '0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (pending_values.size() != 0 &&
                ((words_sent >= CALM_FIRST && words_sent < CALM_LAST) ||
                 $urandom_range(99, 0) >= IDLE_PCT)) begin
                in_ch.valid <= 1'b1;
                in_ch.value <= pending_values.pop_front();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Record the prediction for every word the block takes.
    always @(posedge clk) begin
        if (!rst_n) begin
            words_sent <= 0;
        end else if (in_ch.valid && in_ch.ready) begin
            expected_tallies.insert(expected_tallies.size(),
                                    tally_prime_factors(in_ch.value));
            words_sent <= words_sent + 1;
        end
    end

    // Drive ready: random idling, a calm window, and one long hold-off.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready  <= 1'b0;
            hold_off_left <= 0;
            hold_off_done <= 1'b0;
        end else if (hold_off_left > 0) begin
            out_ch.ready  <= 1'b0;
            hold_off_left <= hold_off_left - 1;
        end else if (!hold_off_done && results_seen == HOLD_OFF_AT) begin
            out_ch.ready  <= 1'b0;
            hold_off_left <= HOLD_OFF_CYCLES;
            hold_off_done <= 1'b1;
        end else begin
            out_ch.ready <= (results_seen >= CALM_FIRST && results_seen < CALM_LAST) ||
                            ($urandom_range(99, 0) >= IDLE_PCT);
        end
    end

    // Compare each result word with the oldest prediction.
    always @(posedge clk) begin
        t_factor_tally want;
        int            errs;
        errs = 0;
        if (!rst_n) begin
            results_seen <= 0;
            mismatches   <= 0;
        end else if (out_ch.valid && out_ch.ready) begin
            results_seen <= results_seen + 1;
            if (expected_tallies.size() == 0) begin
                $error("unexpected result word: factor_count %0d is_prime %0b",
                       out_ch.factor_count, out_ch.is_prime);
                errs++;
            end else begin
                want = expected_tallies.pop_front();
                if (out_ch.factor_count !== want.factor_count) begin
                    $error("value %0d: factor_count expected %0d, got %0d",
                           want.value, want.factor_count, out_ch.factor_count);
                    errs++;
                end
                if (out_ch.is_prime !== want.is_prime) begin
                    $error("value %0d: is_prime expected %0b, got %0b",
                           want.value, want.is_prime, out_ch.is_prime);
                    errs++;
                end
            end
            mismatches <= mismatches + errs;
        end
    end

    // Abort if nothing moves on either side for too long.
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial quiet_cycles = 0;

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+design
design/pfc_pkg.sv
design/pfc_in_if.sv
design/pfc_out_if.sv
design/pfc_divider.sv
design/prime_factor_counter_unit.sv
test/testbench.sv
